// File: sv/tile_row_hue_tone_rotator_core_macros.svh
// Assertion helpers used by the checker of the rotator core
`ifndef TILE_ROW_HUE_TONE_ROTATOR_CORE_MACROS_SVH
`define TILE_ROW_HUE_TONE_ROTATOR_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define TRHR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotator check failed");

// Consequent holds in the cycle after the antecedent
`define TRHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotator check failed");

`endif

// File: sv/trhr_pkg.sv
`default_nettype none

package trhr_pkg;

    localparam int ROW_W = 7;
    localparam int NUM_W = 17;
    localparam int CFG_W = 7;

    localparam int ROW_STEPS  = ROW_W;
    localparam int WRAP_STEPS = NUM_W;

    localparam logic OP_HUE   = 1'b0;
    localparam logic OP_GLINT = 1'b1;

    localparam logic [2:0] REG_GRAPHICS_ON    = 3'd0;
    localparam logic [2:0] REG_CYCLE_HUES     = 3'd1;
    localparam logic [2:0] REG_CYCLE_TONES    = 3'd2;
    localparam logic [2:0] REG_CYCLE_SPAN     = 3'd3;
    localparam logic [2:0] REG_OVERDRAW_FIRST = 3'd4;
    localparam logic [2:0] REG_OVERDRAW_LAST  = 3'd5;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         attr;
        logic signed [15:0] step;
    } trhr_item_t;

    typedef struct packed {
        logic [7:0] new_attr;
        logic       double_height;
    } trhr_result_t;

    typedef struct packed {
        logic [ROW_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [ROW_W-1:0] div;
    } trhr_div_t;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         attr;
        logic signed [15:0] step;
        logic               bypass;
        logic               dbl;
        logic [ROW_W-1:0]   tone;
        logic [ROW_W-1:0]   hue;
        logic [ROW_W-1:0]   pos;
        logic               neg;
    } trhr_ctx_t;

endpackage

`default_nettype wire

// File: sv/trhr_div_cell.sv
`default_nettype none

module trhr_div_cell
    import trhr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      up_valid,
    input  trhr_div_t up_div,
    input  trhr_ctx_t up_ctx,
    output logic      dn_valid,
    output trhr_div_t dn_div,
    output trhr_ctx_t dn_ctx
);

    logic      valid_reg;
    trhr_div_t div_reg;
    trhr_div_t div_next;
    trhr_ctx_t ctx_reg;
    logic [ROW_W:0] trial;
    logic [ROW_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {up_div.rem, up_div.num[NUM_W-1]};
        diff  = trial - {1'b0, up_div.div};
        fits  = trial >= {1'b0, up_div.div};
        div_next.rem = fits ? diff[ROW_W-1:0] : trial[ROW_W-1:0];
        div_next.num = {up_div.num[NUM_W-2:0], 1'b0};
        div_next.quo = {up_div.quo[NUM_W-2:0], fits};
        div_next.div = up_div.div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
            ctx_reg <= up_ctx;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_div   = div_reg;
    assign dn_ctx   = ctx_reg;

endmodule

`default_nettype wire

// File: sv/tile_row_hue_tone_rotator_core.sv
// An accepted item beat passes every cell and then the result register.
// Throughput: one item per cycle; a row of 31 restoring-division cells
// (7 for row/tones, 7 for the hue split, 17 for the wrap) sets the depth.
// The whole row advances together and holds while a result beat is stalled.
// Reset: asynchronous, active low; clears all valid flags and the config registers.
`default_nettype none

module tile_row_hue_tone_rotator_core
    import trhr_pkg::*;
#(
    parameter int GLINT_RANGE = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  trhr_item_t       item,
    output logic             result_valid,
    input  logic             result_stall,
    output trhr_result_t     result,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic [ROW_W-1:0] GLINT_LIM = ROW_W'(GLINT_RANGE);

    logic             graphics_reg;
    logic [ROW_W-1:0] hues_reg;
    logic [ROW_W-1:0] tones_reg;
    logic [ROW_W-1:0] span_reg;
    logic [ROW_W-1:0] first_reg;
    logic [ROW_W-1:0] last_reg;

    logic         en;
    logic         result_valid_reg;
    trhr_result_t result_reg;
    trhr_result_t result_next;

    logic      a_valid [0:ROW_STEPS];
    trhr_div_t a_div   [0:ROW_STEPS];
    trhr_ctx_t a_ctx   [0:ROW_STEPS];
    logic      b_valid [0:ROW_STEPS];
    trhr_div_t b_div   [0:ROW_STEPS];
    trhr_ctx_t b_ctx   [0:ROW_STEPS];
    logic      c_valid [0:WRAP_STEPS];
    trhr_div_t c_div   [0:WRAP_STEPS];
    trhr_ctx_t c_ctx   [0:WRAP_STEPS];

    logic [ROW_W-1:0] row_in;
    logic             enabled;
    logic [ROW_W-1:0] hue;
    logic [ROW_W-1:0] range;
    logic [ROW_W-1:0] pos;
    logic             skip;
    logic [NUM_W-1:0] wrap_sum;
    logic [NUM_W-1:0] wrap_mag;

    trhr_ctx_t        fin_ctx;
    logic [ROW_W-1:0] fin_rem;
    logic [ROW_W-1:0] fin_pos;
    logic [ROW_W-1:0] delta;
    logic [ROW_W-1:0] scale;
    logic [2*ROW_W-1:0] prod;
    logic [ROW_W-1:0] new_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graphics_reg <= 1'b0;
            hues_reg     <= '0;
            tones_reg    <= '0;
            span_reg     <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRAPHICS_ON:    graphics_reg <= cfg_data[0];
                REG_CYCLE_HUES:     hues_reg     <= cfg_data;
                REG_CYCLE_TONES:    tones_reg    <= cfg_data;
                REG_CYCLE_SPAN:     span_reg     <= cfg_data;
                REG_OVERDRAW_FIRST: first_reg    <= cfg_data;
                REG_OVERDRAW_LAST:  last_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;

    // split the row: quotient and remainder by tones
    always_comb
    begin
        row_in  = item.attr[ROW_W-1:0];
        enabled = graphics_reg && (hues_reg > 7'd1) && (tones_reg != '0) &&
                  (span_reg > 7'd1);
        a_valid[0]   = item_valid;
        a_div[0].rem = '0;
        a_div[0].num = {row_in, {(NUM_W-ROW_W){1'b0}}};
        a_div[0].quo = '0;
        a_div[0].div = tones_reg;
        a_ctx[0].opcode = item.opcode;
        a_ctx[0].attr   = item.attr;
        a_ctx[0].step   = item.step;
        a_ctx[0].bypass = !item.attr[7] || !enabled;
        a_ctx[0].dbl    = item.attr[7] && graphics_reg && (first_reg != '0) &&
                          (row_in >= first_reg) && (row_in <= last_reg);
        a_ctx[0].tone   = '0;
        a_ctx[0].hue    = '0;
        a_ctx[0].pos    = '0;
        a_ctx[0].neg    = 1'b0;
    end

    // hue is the row quotient taken modulo hues
    always_comb
    begin
        b_valid[0]   = a_valid[ROW_STEPS];
        b_div[0].rem = '0;
        b_div[0].num = {a_div[ROW_STEPS].quo[ROW_W-1:0], {(NUM_W-ROW_W){1'b0}}};
        b_div[0].quo = '0;
        b_div[0].div = hues_reg;
        b_ctx[0]      = a_ctx[ROW_STEPS];
        b_ctx[0].tone = a_div[ROW_STEPS].rem;
    end

    // wrap position plus step into the rotation range
    always_comb
    begin
        hue = b_div[ROW_STEPS].rem;
        if (b_ctx[ROW_STEPS].opcode == OP_HUE)
        begin
            range = span_reg;
            pos   = hue;
        end
        else
        begin
            range = (tones_reg < GLINT_LIM) ? tones_reg : GLINT_LIM;
            pos   = b_ctx[ROW_STEPS].tone;
        end
        skip     = (range == '0) || (pos >= range);
        wrap_sum = {{(NUM_W-ROW_W){1'b0}}, pos} +
                   {b_ctx[ROW_STEPS].step[15], b_ctx[ROW_STEPS].step};
        wrap_mag = wrap_sum[NUM_W-1] ? (~wrap_sum + 1'b1) : wrap_sum;
        c_valid[0]   = b_valid[ROW_STEPS];
        c_div[0].rem = '0;
        c_div[0].num = wrap_mag;
        c_div[0].quo = '0;
        c_div[0].div = range;
        c_ctx[0]        = b_ctx[ROW_STEPS];
        c_ctx[0].hue    = hue;
        c_ctx[0].pos    = pos;
        c_ctx[0].neg    = wrap_sum[NUM_W-1];
        c_ctx[0].bypass = b_ctx[ROW_STEPS].bypass || skip;
    end

    for (genvar i = 0; i < ROW_STEPS; i++)
    begin : g_row_div
        trhr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (a_valid[i]),
            .up_div   (a_div[i]),
            .up_ctx   (a_ctx[i]),
            .dn_valid (a_valid[i+1]),
            .dn_div   (a_div[i+1]),
            .dn_ctx   (a_ctx[i+1])
        );
    end

    for (genvar i = 0; i < ROW_STEPS; i++)
    begin : g_hue_div
        trhr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (b_valid[i]),
            .up_div   (b_div[i]),
            .up_ctx   (b_ctx[i]),
            .dn_valid (b_valid[i+1]),
            .dn_div   (b_div[i+1]),
            .dn_ctx   (b_ctx[i+1])
        );
    end

    for (genvar i = 0; i < WRAP_STEPS; i++)
    begin : g_wrap_div
        trhr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (c_valid[i]),
            .up_div   (c_div[i]),
            .up_ctx   (c_ctx[i]),
            .dn_valid (c_valid[i+1]),
            .dn_div   (c_div[i+1]),
            .dn_ctx   (c_ctx[i+1])
        );
    end

    // recombine block, hue and tone
    always_comb
    begin
        fin_ctx = c_ctx[WRAP_STEPS];
        fin_rem = c_div[WRAP_STEPS].rem;
        fin_pos = (fin_ctx.neg && (fin_rem != '0)) ?
                  (c_div[WRAP_STEPS].div - fin_rem) : fin_rem;
        delta   = fin_pos - fin_ctx.pos;
        scale   = (fin_ctx.opcode == OP_HUE) ? tones_reg : 7'd1;
        prod    = delta * scale;
        new_row = fin_ctx.attr[ROW_W-1:0] + prod[ROW_W-1:0];
        result_next.new_attr      = fin_ctx.bypass ? fin_ctx.attr : {1'b1, new_row};
        result_next.double_height = fin_ctx.dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= c_valid[WRAP_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: sv/trhr_checker.sv
`default_nettype none
`include "tile_row_hue_tone_rotator_core_macros.svh"

module trhr_checker
    import trhr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_stall,
    input logic         result_valid,
    input logic         result_stall,
    input trhr_result_t result
);

    // hold a stalled result beat
    `TRHR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    // back-pressure comes only from a waiting result
    `TRHR_ASSERT_NOW(a_stall_source, clk, rst_n, item_stall, result_valid && result_stall)
    // advance while the result register is free
    `TRHR_ASSERT_NOW(a_free_accept, clk, rst_n, !result_valid, !item_stall)
    // only a tile can be double height
    `TRHR_ASSERT_NOW(a_dbl_tile, clk, rst_n, result_valid && result.double_height, result.new_attr[7])

endmodule

bind tile_row_hue_tone_rotator_core trhr_checker u_trhr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
